@@ rtl/core/ipv4_security_option_label_extract_defines.svh @@
// Assertion macros used by the checker file of the label extractor.
`ifndef IPV4_SECURITY_OPTION_LABEL_EXTRACT_DEFINES_SVH
`define IPV4_SECURITY_OPTION_LABEL_EXTRACT_DEFINES_SVH

// Property checked on every rising clock edge, switched off while reset is held.
`define IPV4SL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipv4sl: %m failed");

// Property checked on every rising clock edge, reset included.
`define IPV4SL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ipv4sl: %m failed");

`endif

@@ rtl/core/ipv4sl_pkg.sv @@
// Package with the shared types and constants of the label extractor.
`timescale 1ns / 1ps
`default_nettype none
package ipv4sl_pkg;

    // Store size and limits.
    localparam int LABEL_BYTES      = 16;
    localparam int MAX_OPTION_BYTES = 40;
    localparam int RESULT_COUNT     = (LABEL_BYTES < 16) ? LABEL_BYTES : 16;
    localparam int IDX_W            = $clog2(RESULT_COUNT);
    localparam int STORE_IDX_W      = $clog2(LABEL_BYTES);
    localparam int PC_W             = 6;
    localparam int CAP_W            = 5;
    localparam int SNAP_DEPTH       = 2;
    localparam int SNAP_PTR_W       = $clog2(SNAP_DEPTH);
    localparam int SNAP_CNT_W       = $clog2(SNAP_DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Option type codes.
    localparam logic [7:0] OPT_END = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] OPT_SEC = 8'd130;

    // Parse status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_END       = 2'd0;
    localparam t_status ST_LABELED   = 2'd1;
    localparam t_status ST_NOLABEL   = 2'd2;
    localparam t_status ST_MALFORMED = 2'd3;

    // Input word.
    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [7:0] label_byte;
        logic [3:0] byte_index;
        t_status    parse_status;
        logic       last_result;
    } t_out_word;

    // One finished packet: the store bytes to emit and the status.
    typedef struct packed {
        logic [RESULT_COUNT-1:0][7:0] labels;
        t_status                      status;
    } t_snapshot;

    // Queue state seen by the neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage
`default_nettype wire

@@ rtl/core/ipv4sl_front.sv @@
// Front part: option walker, bit packer and label store.
`timescale 1ns / 1ps
`default_nettype none
module ipv4sl_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [ipv4sl_pkg::CAP_W-1:0] i_cfg_wdata,
    input  wire logic                     i_accept,
    input  wire ipv4sl_pkg::t_in_word     i_in,
    output logic                          o_snap_push,
    output ipv4sl_pkg::t_snapshot         o_snap
);
    import ipv4sl_pkg::*;

    typedef enum logic [5:0] {
        PH_TYPE      = 6'b000001,
        PH_LEN_OTHER = 6'b000010,
        PH_LEN_SEC   = 6'b000100,
        PH_SKIP      = 6'b001000,
        PH_SEC_BODY  = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

    logic [CAP_W-1:0]                 r_cap;
    logic [LABEL_BYTES-1:0][7:0]      r_store, n_store;
    t_phase                           r_phase, n_phase;
    logic [5:0]                       r_left, n_left;
    logic [5:0]                       r_offset, n_offset;
    logic [2:0]                       r_bp, n_bp;
    logic [PC_W-1:0]                  r_pc, n_pc;
    t_status                          r_status, n_status;

    logic [CAP_W-1:0]  eff_cap;
    logic [PC_W-1:0]   cap_ext;
    logic [14:0]       pack_bits;
    logic [PC_W-1:0]   hi_idx;
    logic [PC_W:0]     olen;
    logic [7:0]        b;
    logic              do_pack;

    assign b = i_in.opt_byte;

    // Capacity above the store size acts as the store size.
    assign eff_cap = (int'(r_cap) > LABEL_BYTES) ? CAP_W'(LABEL_BYTES) : r_cap;
    assign cap_ext = PC_W'(eff_cap);

    // Seven data bits placed at the current bit position, spanning up to two bytes.
    assign pack_bits = 15'(b[7:1]) << r_bp;
    assign hi_idx    = r_pc + PC_W'(1);

    // Option walk and packing for one accepted byte.
    always_comb begin
        n_store  = r_store;
        n_phase  = r_phase;
        n_left   = r_left;
        n_offset = r_offset;
        n_bp     = r_bp;
        n_pc     = r_pc;
        n_status = r_status;
        do_pack  = 1'b0;
        olen     = '0;

        unique case (r_phase)
            PH_TYPE: begin
                if (b == OPT_END) begin
                    n_status = ST_END;
                    n_phase  = PH_DONE;
                end else if (b != OPT_NOP) begin
                    n_phase  = (b == OPT_SEC) ? PH_LEN_SEC : PH_LEN_OTHER;
                    n_offset = 6'd1;
                end
            end
            PH_LEN_OTHER, PH_LEN_SEC: begin
                if (b < 8'd2 || b > 8'(MAX_OPTION_BYTES)) begin
                    n_status = ST_MALFORMED;
                    n_phase  = PH_DONE;
                end else begin
                    n_left   = b[5:0] - 6'd2;
                    n_offset = 6'd2;
                    if (r_phase == PH_LEN_SEC) begin
                        n_pc = '0;
                        n_bp = '0;
                        if (eff_cap != '0) begin
                            n_store[0] = '0;
                        end
                        // A short security option never labels.
                        n_phase = (n_left == '0) ? PH_TYPE : PH_SEC_BODY;
                    end else begin
                        n_phase = (n_left == '0) ? PH_TYPE : PH_SKIP;
                    end
                end
            end
            PH_SKIP, PH_SEC_BODY: begin
                do_pack = (r_phase == PH_SEC_BODY) && (r_offset >= 6'd3);
                if (do_pack) begin
                    for (int k = 0; k < LABEL_BYTES; k++) begin
                        if (r_pc == PC_W'(k) && r_pc < cap_ext) begin
                            n_store[k] = r_store[k] | pack_bits[7:0];
                        end
                        if (hi_idx == PC_W'(k) && hi_idx < cap_ext && r_bp != '0) begin
                            n_store[k] = {1'b0, pack_bits[14:8]};
                        end
                    end
                    n_pc = (r_bp != '0) ? hi_idx : r_pc;
                    n_bp = r_bp + 3'd7;
                end
                if (r_offset != 6'd63) begin
                    n_offset = r_offset + 6'd1;
                end
                if (r_left != '0) begin
                    n_left = r_left - 6'd1;
                end
                if (n_left == '0) begin
                    n_phase = PH_TYPE;
                    if (r_phase == PH_SEC_BODY) begin
                        olen = {1'b0, n_pc} + (PC_W+1)'(n_bp != '0);
                        if (olen != '0 && olen <= (PC_W+1)'(eff_cap)) begin
                            n_status = ST_LABELED;
                            n_phase  = PH_DONE;
                        end
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // An option still open on the final byte makes the packet malformed.
        if (i_in.last_byte && (n_phase == PH_LEN_OTHER || n_phase == PH_LEN_SEC ||
                               n_phase == PH_SKIP || n_phase == PH_SEC_BODY)) begin
            n_status = ST_MALFORMED;
        end
    end

    // Finished packet goes to the queue on its final byte.
    assign o_snap_push = i_accept && i_in.last_byte;
    always_comb begin
        for (int k = 0; k < RESULT_COUNT; k++) begin
            o_snap.labels[k] = n_store[k];
        end
        o_snap.status = n_status;
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Parser state; cleared again after each packet's final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= '0;
            r_phase  <= PH_TYPE;
            r_left   <= '0;
            r_offset <= '0;
            r_bp     <= '0;
            r_pc     <= '0;
            r_status <= ST_NOLABEL;
        end else if (i_accept) begin
            if (i_in.last_byte) begin
                r_store  <= '0;
                r_phase  <= PH_TYPE;
                r_left   <= '0;
                r_offset <= '0;
                r_bp     <= '0;
                r_pc     <= '0;
                r_status <= ST_NOLABEL;
            end else begin
                r_store  <= n_store;
                r_phase  <= n_phase;
                r_left   <= n_left;
                r_offset <= n_offset;
                r_bp     <= n_bp;
                r_pc     <= n_pc;
                r_status <= n_status;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv4sl_snap_queue.sv @@
// Short queue of finished packets between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module ipv4sl_snap_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire ipv4sl_pkg::t_snapshot   i_snap,
    input  wire logic                    i_pop,
    output ipv4sl_pkg::t_snapshot        o_head,
    output ipv4sl_pkg::t_queue_stat      o_stat
);
    import ipv4sl_pkg::*;

    t_snapshot              r_mem [SNAP_DEPTH];
    logic [SNAP_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [SNAP_CNT_W-1:0]  r_count;
    logic                   do_push, do_pop;

    assign o_stat.full  = (r_count == SNAP_CNT_W'(SNAP_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_snap;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == SNAP_PTR_W'(SNAP_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + SNAP_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == SNAP_PTR_W'(SNAP_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + SNAP_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + SNAP_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - SNAP_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv4sl_emit.sv @@
// Back part: walks the head packet and hands out one result word per pop.
`timescale 1ns / 1ps
`default_nettype none
module ipv4sl_emit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ipv4sl_pkg::t_snapshot   i_head,
    input  wire ipv4sl_pkg::t_queue_stat i_stat,
    input  wire logic                    i_pop,
    output ipv4sl_pkg::t_out_word        o_out,
    output logic                         o_empty,
    output logic                         o_head_pop
);
    import ipv4sl_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             at_last;
    logic             take;

    assign at_last    = (r_idx == IDX_W'(RESULT_COUNT - 1));
    assign o_empty    = i_stat.empty;
    assign take       = i_pop && !i_stat.empty;
    assign o_head_pop = take && at_last;

    // Result word for the current store position.
    assign o_out.label_byte   = i_head.labels[r_idx];
    assign o_out.byte_index   = 4'(r_idx);
    assign o_out.parse_status = i_head.status;
    assign o_out.last_result  = at_last;

    // Position within the head packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= at_last ? '0 : r_idx + IDX_W'(1);
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ipv4_security_option_label_extract.sv @@
// Top level of the IPv4 security option label extractor.
//
//  Channel   Direction  Handshake                 Word
//  options   in         push / full               opt_byte, last_byte
//  results   out        empty / pop               label_byte, byte_index, status, last
//  config    in         i_cfg_we / i_cfg_wdata    label capacity, 5 bits
//
// One option byte is taken per cycle while full is low; the parser state updates in the same cycle.
// A packet's final byte yields 16 result words, one per cycle from the back part while pop is high.
// Two finished packets can wait in the queue; full rises only when both slots hold.
// Reset is synchronous and clears the parser, queue and emitter; capacity goes to 16.
// A stalled pop holds the result word; the front keeps taking bytes meanwhile until full rises.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_security_option_label_extract (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire ipv4sl_pkg::t_in_word          i_in,
    output logic                               empty,
    input  wire logic                          pop,
    output ipv4sl_pkg::t_out_word              o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ipv4sl_pkg::CAP_W-1:0]  i_cfg_wdata
);
    import ipv4sl_pkg::*;

    t_snapshot   snap, head;
    t_queue_stat qstat;
    logic        snap_push, head_pop, accept;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    // Front: parse and pack.
    ipv4sl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_snap_push (snap_push),
        .o_snap      (snap)
    );

    // Queue of finished packets.
    ipv4sl_snap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (snap_push),
        .i_snap  (snap),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Back: emit result words.
    ipv4sl_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_stat     (qstat),
        .i_pop      (pop),
        .o_out      (o_out),
        .o_empty    (empty),
        .o_head_pop (head_pop)
    );

endmodule
`default_nettype wire

@@ rtl/core/ipv4sl_checker.sv @@
// Port checker for the label extractor and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_security_option_label_extract_defines.svh"
module ipv4sl_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire ipv4sl_pkg::t_out_word         o_out
);
    import ipv4sl_pkg::*;

    // Reset leaves no result words waiting.
    `IPV4SL_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n |=> empty))

    // Within a packet the words come in store order with one status.
    `IPV4SL_ASSERT(a_run_order, i_clk, i_rst_n,
        ((pop && !empty && !o_out.last_result) |=> (!empty
            && o_out.byte_index == $past(o_out.byte_index) + 4'd1
            && o_out.parse_status == $past(o_out.parse_status))))

    // A new packet's words start at store position zero.
    `IPV4SL_ASSERT(a_run_start, i_clk, i_rst_n,
        ((pop && !empty && o_out.last_result) |=> (empty || o_out.byte_index == 4'd0)))

    // A waiting word holds while it is not taken.
    `IPV4SL_ASSERT(a_hold, i_clk, i_rst_n, ((!empty && !pop) |=> (!empty && $stable(o_out))))

endmodule

bind ipv4_security_option_label_extract ipv4sl_checker u_checker (.*);
`default_nettype wire

@@ tb/sv/ipv4_security_option_label_extract_tb.sv @@
// Testbench for the IPv4 security option label extractor, with predictor and scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_security_option_label_extract_tb;
    import ipv4sl_pkg::*;

    // Option codes and limits used by the stimulus and the predictor.
    localparam logic [7:0] OPT_RECORD_ROUTE = 8'd7;
    localparam logic [7:0] OPT_TIMESTAMP    = 8'd68;
    localparam int         MIN_OPTION_LEN   = 2;
    localparam int         SEC_BODY_START   = 3;
    localparam int         OFFSET_LIMIT     = 63;
    localparam int         PACKED_LIMIT     = 127;
    localparam int         SETTLE_CYCLES    = 24;
    localparam int         PHASE_ITEMS      = 15;
    localparam int         HOLD_OFF_CYCLES  = 300;
    localparam int         PRINT_LIMIT      = 40;

    typedef logic [7:0] byte_q_t [$];

    // Where the option walk stands between bytes.
    typedef enum logic [2:0] {
        WALK_TYPE,
        WALK_LEN,
        WALK_SEC_LEN,
        WALK_SKIP,
        WALK_SEC_BODY,
        WALK_DONE
    } walk_t;

    // Predicts the label words of each packet and checks them as they come out.
    class label_scoreboard;
        t_out_word  label_words_due [$];
        int         mismatches;
        int         capacity;
        logic [7:0] label_store [LABEL_BYTES];
        walk_t      walk;
        int         opt_left;
        int         opt_offset;
        int         bit_pos;
        int         packed_bytes;
        t_status    status;

        function new();
            mismatches = 0;
            capacity   = CAP_RESET;
            clear_packet();
        endfunction

        function void clear_packet();
            foreach (label_store[i]) label_store[i] = 8'h00;
            walk         = WALK_TYPE;
            opt_left     = 0;
            opt_offset   = 0;
            bit_pos      = 0;
            packed_bytes = 0;
            status       = ST_NOLABEL;
        endfunction

        function int usable_capacity();
            return (capacity > LABEL_BYTES) ? LABEL_BYTES : capacity;
        endfunction

        // Drops the extension bit and packs bits 1 to 7 LSB-first into the store.
        function void pack_label_bits(logic [7:0] b);
            int cap;
            cap = usable_capacity();
            for (int k = 1; k < 8; k++) begin
                if (packed_bytes < cap)
                    label_store[packed_bytes][bit_pos] = label_store[packed_bytes][bit_pos] | b[k];
                bit_pos++;
                if (bit_pos == 8) begin
                    bit_pos = 0;
                    if (packed_bytes < PACKED_LIMIT)
                        packed_bytes++;
                    if (packed_bytes < cap)
                        label_store[packed_bytes] = 8'h00;
                end
            end
        endfunction

        // A finished security option labels the packet when its label fits.
        function void close_option(bit is_sec);
            int used;
            walk = WALK_TYPE;
            if (is_sec) begin
                used = packed_bytes + ((bit_pos != 0) ? 1 : 0);
                if (used > 0 && used <= usable_capacity()) begin
                    status = ST_LABELED;
                    walk   = WALK_DONE;
                end
            end
        endfunction

        // Advances the walk by one accepted option byte; the final byte yields the words.
        function void take_option_byte(t_in_word w);
            logic [7:0] b;
            bit         in_sec;
            t_out_word  word;
            b = w.opt_byte;
            case (walk)
                WALK_TYPE: begin
                    if (b == OPT_END) begin
                        status = ST_END;
                        walk   = WALK_DONE;
                    end else if (b != OPT_NOP) begin
                        walk       = (b == OPT_SEC) ? WALK_SEC_LEN : WALK_LEN;
                        opt_offset = 1;
                    end
                end
                WALK_LEN, WALK_SEC_LEN: begin
                    if (b < MIN_OPTION_LEN || b > MAX_OPTION_BYTES) begin
                        status = ST_MALFORMED;
                        walk   = WALK_DONE;
                    end else begin
                        opt_left   = int'(b) - MIN_OPTION_LEN;
                        opt_offset = 2;
                        if (walk == WALK_SEC_LEN) begin
                            packed_bytes = 0;
                            bit_pos      = 0;
                            if (usable_capacity() > 0)
                                label_store[0] = 8'h00;
                            if (opt_left == 0)
                                close_option(1'b1);
                            else
                                walk = WALK_SEC_BODY;
                        end else begin
                            if (opt_left == 0)
                                close_option(1'b0);
                            else
                                walk = WALK_SKIP;
                        end
                    end
                end
                WALK_SKIP, WALK_SEC_BODY: begin
                    in_sec = (walk == WALK_SEC_BODY);
                    if (in_sec && opt_offset >= SEC_BODY_START)
                        pack_label_bits(b);
                    if (opt_offset < OFFSET_LIMIT)
                        opt_offset++;
                    if (opt_left > 0)
                        opt_left--;
                    if (opt_left == 0)
                        close_option(in_sec);
                end
                default: ;
            endcase

            if (w.last_byte) begin
                // An option still open on the final byte makes the packet malformed.
                if (walk inside {WALK_LEN, WALK_SEC_LEN, WALK_SKIP, WALK_SEC_BODY})
                    status = ST_MALFORMED;
                for (int k = 0; k < RESULT_COUNT; k++) begin
                    word.label_byte   = label_store[k];
                    word.byte_index   = 4'(k);
                    word.parse_status = status;
                    word.last_result  = (k == RESULT_COUNT - 1);
                    label_words_due.push_back(word);
                end
                clear_packet();
            end
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_label_word(t_out_word got);
            t_out_word want;
            if (label_words_due.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = label_words_due.pop_front();
                if (got.label_byte !== want.label_byte)
                    report($sformatf("label_byte %h, want %h (index %0d)",
                                     got.label_byte, want.label_byte, want.byte_index));
                if (got.byte_index !== want.byte_index)
                    report($sformatf("byte_index %h, want %h", got.byte_index, want.byte_index));
                if (got.parse_status !== want.parse_status)
                    report($sformatf("parse_status %h, want %h (index %0d)",
                                     got.parse_status, want.parse_status, want.byte_index));
                if (got.last_result !== want.last_result)
                    report($sformatf("last_result %b, want %b (index %0d)",
                                     got.last_result, want.last_result, want.byte_index));
            end
        endtask
    endclass

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 pop         = 1'b0;
    t_in_word             i_in        = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata = '0;
    logic                 full;
    logic                 empty;
    t_out_word            o_out;

    label_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int send_modes [4] = '{0, 48, 0, 31};
    int recv_modes [4] = '{0, 0, 48, 31};

    ipv4_security_option_label_extract u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: sample at the rising edge, decide the next pop at the falling edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_label_word(o_out);
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one word after a random idle gap and waits until it is taken.
    task automatic offer_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (full);
        sb.take_option_byte(w);
    endtask

    task automatic send_packet(input byte_q_t pkt);
        foreach (pkt[i])
            offer_word(t_in_word'{opt_byte: pkt[i], last_byte: (i == pkt.size() - 1)});
    endtask

    // Stops sending and lets the block drain completely.
    task automatic drain_block();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.label_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CAP_W'(value);
        @(posedge i_clk);
        sb.capacity = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Builds one options area: mostly well-formed, some truncated, bad lengths or noise.
    function automatic void make_packet(input bit short_only, output byte_q_t pkt);
        int         shape;
        int         len;
        int         cut;
        logic [7:0] kind;
        pkt = {};
        shape = short_only ? 100 : $urandom_range(99);
        if (shape < 85) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(9))
                    0, 1: pkt.push_back(OPT_NOP);
                    2, 3, 4, 5: begin
                        len = ($urandom_range(7) == 0) ?
                              $urandom_range(MIN_OPTION_LEN, MAX_OPTION_BYTES) :
                              $urandom_range(4, 10);
                        pkt.push_back(OPT_SEC);
                        pkt.push_back(8'(len));
                        repeat (len - MIN_OPTION_LEN) pkt.push_back(8'($urandom_range(255)));
                    end
                    6, 7, 8: begin
                        kind = 8'($urandom_range(2, 255));
                        if (kind == OPT_SEC)
                            kind++;
                        len = $urandom_range(MIN_OPTION_LEN, 8);
                        pkt.push_back(kind);
                        pkt.push_back(8'(len));
                        repeat (len - MIN_OPTION_LEN) pkt.push_back(8'($urandom_range(255)));
                    end
                    default: begin
                        pkt.push_back(OPT_END);
                        repeat ($urandom_range(3)) pkt.push_back(8'($urandom_range(255)));
                    end
                endcase
            end
            // Cut the area short so that an option may be left open.
            if (shape >= 70 && pkt.size() > 1) begin
                cut = $urandom_range(1, pkt.size() - 1);
                while (pkt.size() > cut)
                    void'(pkt.pop_back());
            end
        end else if (shape < 93) begin
            if ($urandom_range(1))
                pkt.push_back(OPT_NOP);
            pkt.push_back($urandom_range(1) ? OPT_SEC : OPT_TIMESTAMP);
            case ($urandom_range(2))
                0: pkt.push_back(8'd0);
                1: pkt.push_back(8'd1);
                default: pkt.push_back(8'($urandom_range(MAX_OPTION_BYTES + 1, 255)));
            endcase
            repeat ($urandom_range(2)) pkt.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, short_only ? 3 : 6))
                pkt.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Main sequence: reset, directed packets, then random phases over capacities.
    initial begin
        byte_q_t pkt;
        int      caps [8];
        int      sent;
        caps = '{1, 31, 0, 16, 8, 2, 17, 0};
        caps[7] = $urandom_range(31);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed packets at the reset capacity and without idling.
        send_packet({OPT_END});
        send_packet({OPT_SEC, 8'd4, 8'h55, 8'hFF});
        send_packet({OPT_NOP, OPT_SEC, 8'd2, OPT_RECORD_ROUTE});
        send_packet({OPT_TIMESTAMP, 8'd1});
        send_packet({OPT_SEC, 8'd41});
        send_packet({OPT_SEC, 8'd3, 8'h00});
        send_packet({OPT_RECORD_ROUTE, 8'd3, 8'hAA, OPT_NOP});
        send_packet({OPT_END, 8'hFF, 8'h44});
        send_packet({OPT_SEC, 8'd10, 8'h01, 8'hFE});

        for (int p = 0; p < 8; p++) begin
            drain_block();
            write_capacity(caps[p]);
            send_idle_pct  = send_modes[(p + 1) % 4];
            recv_stall_pct = recv_modes[(p + 1) % 4];
            // One phase keeps the result side blocked so that the queue fills up.
            if (p == 3)
                hold_cycles = HOLD_OFF_CYCLES;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                make_packet(p == 3, pkt);
                send_packet(pkt);
                sent += pkt.size();
            end
        end

        drain_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.label_words_due.size() != 0)
            sb.report($sformatf("%0d words never came", sb.label_words_due.size()));

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ipv4sl_pkg.sv
rtl/core/ipv4sl_front.sv
rtl/core/ipv4sl_snap_queue.sv
rtl/core/ipv4sl_emit.sv
rtl/core/ipv4_security_option_label_extract.sv
rtl/core/ipv4sl_checker.sv
tb/sv/ipv4_security_option_label_extract_tb.sv
